@@ rtl/rct_pkg.sv @@
// Shared types and constants of the re-identification confirmation tracker.
`default_nettype none
package rct_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_MAX_AGE        = 3'd0;
  localparam logic [2:0] REG_MAX_DISTANCE   = 3'd1;
  localparam logic [2:0] REG_MIN_APPEARANCE = 3'd2;
  localparam logic [2:0] REG_MIN_SCORE      = 3'd3;
  localparam logic [2:0] REG_CONFIRM_FRAMES = 3'd4;

  // Item kinds and lifecycle codes.
  localparam logic       KIND_EVIDENCE  = 1'b0;
  localparam logic       KIND_CLEAR     = 1'b1;
  localparam logic [1:0] LIFE_OTHER     = 2'd0;
  localparam logic [1:0] LIFE_ARCHIVED  = 2'd3;

  // Q15 unity and the reciprocal used for the divide by 100.
  localparam logic [15:0] Q15_ONE     = 16'd32768;
  localparam logic [22:0] RECIP_100   = 23'd5368710;
  localparam int          RECIP_SHIFT = 29;

  typedef enum logic [2:0] {
    DEC_CONFIRMED   = 3'd0,
    DEC_TENTATIVE   = 3'd1,
    DEC_GATE_REJECT = 3'd2,
    DEC_SCORE_REJECT = 3'd3,
    DEC_ARCHIVED    = 3'd4,
    DEC_INVALID     = 3'd5,
    DEC_FRAME_ORDER = 3'd6
  } decision_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  object_index;
    logic [31:0] cand_id;
    logic [31:0] frame_no;
    logic [1:0]  lifecycle;
    logic        domain_ok;
    logic [47:0] age_ns;
    logic [19:0] distance_mm;
    logic [15:0] appearance_sim;
    logic [15:0] geometry_sim;
    logic [15:0] semantic_sim;
  } item_t;

  typedef struct packed {
    decision_t   decision;
    logic [7:0]  slot_echo;
    logic [31:0] candidate_echo;
    logic [15:0] hit_count;
    logic [15:0] score;
    logic        event_flag;
  } result_t;

  // One slot of the table as stored in memory.
  typedef struct packed {
    logic        seen;
    logic [31:0] prev_frame;
    logic [31:0] candidate;
    logic [15:0] hits;
    logic        confirmed;
  } slot_entry_t;

endpackage
`default_nettype wire

@@ rtl/rct_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module rct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/reid_confirmation_tracker_top.sv @@
// Top level of the re-identification confirmation tracker.
// The result strobe done is registered from the execute state, which follows the
// read and score states. A new evidence item is taken only while busy is low; busy
// is high through the read, score and write-back sequence around the single slot memory.
// A clear item, and reset, run a zeroing pass over all OBJECT_SLOTS slots of the slot
// memory with busy high; configuration registers return to their defaults on reset.
// The receiver cannot stall: done is high for exactly one cycle per result.
`default_nettype none
module reid_confirmation_tracker_top
  import rct_pkg::*;
#(
  parameter int OBJECT_SLOTS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire item_t       item,
  output logic             done,
  output result_t          result,
  input  wire logic        wr_en,
  input  wire logic [2:0]  wr_index,
  input  wire logic [47:0] wr_data
);

  localparam int AW = (OBJECT_SLOTS > 1) ? $clog2(OBJECT_SLOTS) : 1;
  localparam int EW = $bits(slot_entry_t);
  localparam logic [AW-1:0] LAST_SLOT = AW'(OBJECT_SLOTS - 1);

  // The sequencer walks every evidence item through read, score and execute.
  // Only one item is in flight, so no item reads a slot before the previous item's write to it is done.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_READ  = 5'b00010,
    S_SCORE = 5'b00100,
    S_EXEC  = 5'b01000,
    S_CLEAR = 5'b10000
  } state_t;

  state_t state, state_next;

  // Configuration registers.
  logic [47:0] max_age_ns;
  logic [19:0] max_distance_mm;
  logic [15:0] min_appearance;
  logic [15:0] min_combined_score;
  logic [15:0] confirm_frames;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_age_ns         <= 48'd1000000000;
      max_distance_mm    <= 20'd2000;
      min_appearance     <= 16'd16384;
      min_combined_score <= 16'd19661;
      confirm_frames     <= 16'd3;
    end else if (wr_en) begin
      case (wr_index)
        REG_MAX_AGE:        max_age_ns         <= wr_data;
        REG_MAX_DISTANCE:   max_distance_mm    <= wr_data[19:0];
        REG_MIN_APPEARANCE: min_appearance     <= wr_data[15:0];
        REG_MIN_SCORE:      min_combined_score <= wr_data[15:0];
        REG_CONFIRM_FRAMES: confirm_frames     <= wr_data[15:0];
        default: ;
      endcase
    end
  end

  // The accepted item is held for the whole sequence.
  item_t        cur;
  logic         accept;
  logic [AW-1:0] clear_addr;
  logic [21:0]  weighted;
  logic [44:0]  score_prod;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= item;
    end
  end

  // Slot memory: the item's slot is read every cycle; writes come from the
  // execute step or from the zeroing pass.
  slot_entry_t   entry;
  slot_entry_t   entry_next;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  slot_entry_t   mem_wdata;
  logic [EW-1:0] mem_rdata;

  assign entry = slot_entry_t'(mem_rdata);

  rct_ram #(
    .WIDTH(EW),
    .DEPTH(OBJECT_SLOTS)
  ) u_slots (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_addr(AW'(cur.object_index)),
    .rd_data(mem_rdata)
  );

  // Weighted sum 60a + 25g + 15s, exact and at most 3276800 for valid similarity inputs.
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      weighted <= 22'(cur.appearance_sim) * 22'd60
                + 22'(cur.geometry_sim) * 22'd25
                + 22'(cur.semantic_sim) * 22'd15;
    end
  end

  // Rounded divide by 100 as a reciprocal multiply; the shift is exact for the
  // whole range of the weighted sum.
  always_ff @(posedge clk) begin
    if (state == S_SCORE) begin
      score_prod <= 45'(weighted + 22'd50) * 45'(RECIP_100);
    end
  end

  // Execute step: checks, gating, hit counting and the slot update.
  logic        invalid, frame_err, consecutive, gated, score_low;
  logic [15:0] score_val;
  logic [15:0] hits_new;
  result_t     res_next;

  always_comb begin
    score_val   = score_prod[RECIP_SHIFT+15:RECIP_SHIFT];
    invalid     = (cur.cand_id == 32'd0) || (cur.appearance_sim > Q15_ONE)
               || (cur.geometry_sim > Q15_ONE) || (cur.semantic_sim > Q15_ONE)
               || (32'(cur.object_index) >= 32'(OBJECT_SLOTS));
    frame_err   = entry.seen && (cur.frame_no <= entry.prev_frame);
    consecutive = !entry.seen || (cur.frame_no == 32'(entry.prev_frame + 32'd1));
    gated       = (cur.lifecycle == LIFE_OTHER) || !cur.domain_ok
               || (cur.age_ns > max_age_ns) || (cur.distance_mm > max_distance_mm);
    score_low   = (cur.appearance_sim < min_appearance)
               || ({1'b0, weighted} < 23'(min_combined_score) * 23'd100);

    entry_next            = entry;
    entry_next.seen       = 1'b1;
    entry_next.prev_frame = cur.frame_no;
    hits_new              = 16'd0;

    res_next.decision       = DEC_INVALID;
    res_next.slot_echo      = cur.object_index;
    res_next.candidate_echo = cur.cand_id;
    res_next.hit_count      = 16'd0;
    res_next.score          = 16'd0;
    res_next.event_flag     = 1'b0;

    if (invalid) begin
      res_next.decision = DEC_INVALID;
    end else if (frame_err) begin
      res_next.decision = DEC_FRAME_ORDER;
    end else if (cur.lifecycle == LIFE_ARCHIVED) begin
      entry_next.hits      = 16'd0;
      entry_next.confirmed = 1'b0;
      res_next.decision    = DEC_ARCHIVED;
    end else if (gated) begin
      entry_next.hits      = 16'd0;
      entry_next.confirmed = 1'b0;
      res_next.decision    = DEC_GATE_REJECT;
    end else if (score_low) begin
      entry_next.hits      = 16'd0;
      entry_next.confirmed = 1'b0;
      res_next.decision    = DEC_SCORE_REJECT;
      res_next.score       = score_val;
    end else begin
      // A new run starts on a frame gap or a different candidate; an ongoing run
      // counts until it is confirmed, saturating at the counter's top.
      if (!consecutive || (entry.candidate != cur.cand_id)) begin
        entry_next.candidate = cur.cand_id;
        entry_next.hits      = 16'd1;
        entry_next.confirmed = 1'b0;
      end else if (!entry.confirmed && (entry.hits != 16'hFFFF)) begin
        entry_next.hits = entry.hits + 16'd1;
      end
      hits_new           = entry_next.hits;
      res_next.hit_count = hits_new;
      res_next.score     = score_val;
      if (hits_new < confirm_frames) begin
        res_next.decision = DEC_TENTATIVE;
      end else begin
        res_next.decision    = DEC_CONFIRMED;
        res_next.event_flag  = !entry_next.confirmed;
        entry_next.confirmed = 1'b1;
      end
    end
  end

  // Memory write port: the zeroing pass owns it while it runs.
  always_comb begin
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clear_addr;
      mem_wdata = '0;
    end else begin
      mem_we    = (state == S_EXEC) && !invalid && !frame_err;
      mem_waddr = AW'(cur.object_index);
      mem_wdata = entry_next;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (item.kind == KIND_CLEAR) ? S_CLEAR : S_READ;
        end
      end
      S_READ:  state_next = S_SCORE;
      S_SCORE: state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      S_CLEAR: begin
        if (clear_addr == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      done       <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == S_EXEC);
      if (state == S_CLEAR) begin
        clear_addr <= (clear_addr == LAST_SLOT) ? '0 : clear_addr + AW'(1);
      end
    end
  end

  // The result register holds the transfer for its one strobe cycle.
  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      result <= res_next;
    end
  end

endmodule
`default_nettype wire
